[src/sle_pkg.sv]
package sle_pkg;

  localparam logic [7:0] KEY_BACKSPACE = 8'd8;
  localparam logic [7:0] KEY_RETURN    = 8'd13;
  localparam logic [7:0] PRINT_LOW     = 8'd32;
  localparam logic [7:0] PRINT_HIGH    = 8'd126;

  localparam int unsigned CHAR_W = 7;
  localparam int unsigned LEN_W  = 6;

  typedef enum logic [1:0] {
    CLS_IGNORE,
    CLS_BKSP,
    CLS_PRINT,
    CLS_RETURN
  } byte_class_e;

endpackage

[src/sle_ram.sv]
module sle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/sle_dec.sv]
module sle_dec (
  input  logic                      [7:0] rx_byte_i,
  output sle_pkg::byte_class_e            cls_o
);

  import sle_pkg::*;

  always_comb begin
    if (rx_byte_i == KEY_BACKSPACE) begin
      cls_o = CLS_BKSP;
    end else if (rx_byte_i == KEY_RETURN) begin
      cls_o = CLS_RETURN;
    end else if (rx_byte_i >= PRINT_LOW && rx_byte_i <= PRINT_HIGH) begin
      cls_o = CLS_PRINT;
    end else begin
      cls_o = CLS_IGNORE;
    end
  end

endmodule

[src/serial_line_editor.sv]
// Line buffer for received serial bytes. Backspace drops the last stored
// character, printable bytes are stored while the count is below
// min(max_chars, LINE_DEPTH-1), other bytes are ignored. Carriage return
// sends the stored characters in order, each with the line length, then a
// zero terminator flagged is_last, and starts a new line. Backspace,
// printable and ignored bytes do not stall the input. A carriage return
// holds the input stalled while each stored character is read through
// the single registered read port of the line store and passed out, then
// the terminator; output stalls extend it. max_chars may be written only
// while the block is idle; reset value is 63.
module serial_line_editor #(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_we_i,
  input  logic [sle_pkg::LEN_W-1:0]   cfg_data_i,

  input  logic                        rx_valid_i,
  output logic                        rx_stall_o,
  input  logic [7:0]                  rx_byte_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sle_pkg::CHAR_W-1:0]  out_char_o,
  output logic [sle_pkg::LEN_W-1:0]   line_length_o,
  output logic                        is_last_o
);

  import sle_pkg::*;

  localparam int unsigned CNT_W = $clog2(LINE_DEPTH);
  localparam logic [8:0]  CAP   = 9'(LINE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_TERM = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  max_q;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic              out_last_q, out_last_d;

  byte_class_e       cls;
  logic              rx_take;
  logic              slot_free;
  logic [8:0]        limit;
  logic              ram_we, ram_re;
  logic [CHAR_W-1:0] ram_rdata;

  sle_dec u_dec (
    .rx_byte_i (rx_byte_i),
    .cls_o     (cls)
  );

  sle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (rx_byte_i[CHAR_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rx_stall_o = (state_q != ST_IDLE);
  assign rx_take    = rx_valid_i && !rx_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign limit      = (9'(max_q) < CAP) ? 9'(max_q) : CAP;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (rx_take) begin
          case (cls)
            CLS_BKSP: begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            CLS_PRINT: begin
              if (9'(cnt_q) < limit) begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
              end
            end
            CLS_RETURN: begin
              idx_d   = '0;
              state_d = (cnt_q != '0) ? ST_READ : ST_TERM;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ram_rdata;
          out_len_d   = LEN_W'(cnt_q);
          out_last_d  = 1'b0;
          idx_d       = idx_q + 1'b1;
          state_d     = (idx_q == cnt_q - 1'b1) ? ST_TERM : ST_READ;
        end
      end
      ST_TERM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = '0;
          out_len_d   = LEN_W'(cnt_q);
          out_last_d  = 1'b1;
          cnt_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      max_q       <= LEN_W'(63);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign line_length_o = out_len_q;
  assign is_last_o     = out_last_q;

endmodule
